[src/msr_pkg.sv]
// ---------------------------------------------------------------------------
// msr_pkg
// Shared types and constants for the H-bridge motor speed ramp generator.
// ---------------------------------------------------------------------------
package msr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // Velocity limits, percent
  localparam logic signed [7:0] VEL_MAX = 8'sd100;
  localparam logic signed [7:0] VEL_MIN = -8'sd100;

  // Quotient bits produced by the serial divider (|velocity| <= 100 < 128)
  localparam int Q_BITS = 7;

  // Input word
  typedef struct packed {
    logic [1:0]        kind;
    logic              motor_sel;
    logic signed [7:0] start_velocity;
    logic signed [7:0] end_velocity;
    logic [23:0]       ramp_ticks;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              motor_out;
    logic signed [7:0] velocity;
    logic [6:0]        duty;
    logic              pin_one;
    logic              pin_two;
    logic              ramp_active;
  } out_word_t;

endpackage

[src/msr_divider.sv]
// ---------------------------------------------------------------------------
// msr_divider
// Restoring serial divider: signed numerator over a positive tick span,
// one quotient bit per cycle, quotient truncated toward zero.
// ---------------------------------------------------------------------------
module msr_divider
  import msr_pkg::*;
#(
  parameter int TICK_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [TICK_BITS+9:0] num,
  input  logic [TICK_BITS-1:0]        den,
  output logic                        done,
  output logic signed [7:0]           quot
);

  localparam int NUM_W = TICK_BITS + 10;
  localparam int DVS_W = TICK_BITS + Q_BITS - 1;
  localparam int CNT_W = $clog2(Q_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [Q_BITS-1:0]   q_r, q_nxt;
  logic                neg_r, neg_nxt;

  logic [NUM_W-1:0]    num_mag;
  logic [NUM_W-1:0]    dvs_ext;
  logic                fits;
  logic signed [7:0]   q_pos;

  // magnitude of the numerator
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // one trial subtraction per cycle
  assign dvs_ext = NUM_W'(dvs_r);
  assign fits    = (rem_r >= dvs_ext);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(Q_BITS - 1);
      rem_nxt  = num_mag;
      dvs_nxt  = DVS_W'({den, {(Q_BITS-1){1'b0}}});
      q_nxt    = '0;
      neg_nxt  = num[NUM_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? rem_r - dvs_ext : rem_r;
      q_nxt   = {q_r[Q_BITS-2:0], fits};
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  // sign fix-up: truncation toward zero
  assign q_pos = $signed({1'b0, q_r});
  assign quot  = neg_r ? -q_pos : q_pos;
  assign done  = done_r;

endmodule

[src/motor_speed_ramp_hbridge.sv]
// Tick during a ramp: two multiply steps, operand load, 7-step serial divide,
// result load; other words go straight to result load.
// One word in flight: in_stall is high from acceptance until the result is
// loaded into the output register, so no new word is taken until then.
// Synchronous active-low reset: no ramp, motor A, velocity 0 (pin_two high).
// ---------------------------------------------------------------------------
// motor_speed_ramp_hbridge
// Linear speed ramp generator with H-bridge duty and direction outputs.
// ---------------------------------------------------------------------------
module motor_speed_ramp_hbridge
  import msr_pkg::*;
#(
  parameter int TICK_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int NUM_W = TICK_BITS + 10;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL1  = 6'b000010,
    S_MUL2  = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                    active_r, active_nxt;
  logic                    motor_r, motor_nxt;
  logic signed [7:0]       from_r, from_nxt;
  logic signed [7:0]       to_r, to_nxt;
  logic [TICK_BITS-1:0]    span_r, span_nxt;
  logic [TICK_BITS:0]      elapsed_r, elapsed_nxt;
  logic signed [7:0]       vel_r, vel_nxt;
  logic signed [NUM_W-1:0] prod_r, prod_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic                    accept;
  logic signed [7:0]       s_clamp, e_clamp;
  logic [TICK_BITS-1:0]    span_in;
  logic [TICK_BITS:0]      elapsed_inc;
  logic signed [8:0]       diff;
  logic signed [NUM_W-1:0] p_from, p_step;
  logic                    div_start, div_done;
  logic signed [7:0]       div_quot;
  logic                    out_free;
  logic [6:0]              mag;

  function automatic logic signed [7:0] clamp_vel(input logic signed [7:0] v);
    if (v > VEL_MAX) begin
      return VEL_MAX;
    end else if (v < VEL_MIN) begin
      return VEL_MIN;
    end
    return v;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign s_clamp     = clamp_vel(in_word.start_velocity);
  assign e_clamp     = clamp_vel(in_word.end_velocity);
  assign span_in     = TICK_BITS'(in_word.ramp_ticks);
  assign elapsed_inc = elapsed_r + 1'b1;

  // ramp numerator terms: from*span, then elapsed*(to-from)
  assign diff   = {to_r[7], to_r} - {from_r[7], from_r};
  assign p_from = from_r * $signed({1'b0, span_r});
  assign p_step = $signed({1'b0, elapsed_r}) * diff;

  assign div_start = (state_r == S_DLOAD);

  msr_divider #(
    .TICK_BITS (TICK_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // drive word from the present state
  assign mag = vel_r[7] ? 7'(-vel_r) : 7'(vel_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    motor_nxt     = motor_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    span_nxt      = span_r;
    elapsed_nxt   = elapsed_r;
    vel_nxt       = vel_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OUT;
          if (in_word.kind == KIND_START) begin
            motor_nxt   = in_word.motor_sel;
            from_nxt    = s_clamp;
            to_nxt      = e_clamp;
            span_nxt    = span_in;
            elapsed_nxt = '0;
            if (s_clamp == e_clamp || span_in == '0) begin
              active_nxt = 1'b0;
              vel_nxt    = e_clamp;
            end else begin
              active_nxt = 1'b1;
              vel_nxt    = s_clamp;
            end
          end else if (in_word.kind == KIND_TICK) begin
            if (active_r) begin
              elapsed_nxt = elapsed_inc;
              if (elapsed_inc > {1'b0, span_r}) begin
                active_nxt = 1'b0;
              end else begin
                state_nxt = S_MUL1;
              end
            end
          end else if (in_word.kind == KIND_ABORT) begin
            active_nxt = 1'b0;
          end
        end
      end
      S_MUL1: begin
        prod_nxt  = p_from;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        num_nxt   = prod_r + p_step;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          vel_nxt   = div_quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.motor_out   = motor_r;
          out_word_nxt.velocity    = vel_r;
          out_word_nxt.duty        = mag;
          out_word_nxt.pin_one     = vel_r[7];
          out_word_nxt.pin_two     = !vel_r[7];
          out_word_nxt.ramp_active = active_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      motor_r     <= 1'b0;
      from_r      <= '0;
      to_r        <= '0;
      span_r      <= '0;
      elapsed_r   <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      motor_r     <= motor_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      span_r      <= span_nxt;
      elapsed_r   <= elapsed_nxt;
      vel_r       <= vel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and output word
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[src/msr_checker.sv]
// ---------------------------------------------------------------------------
// msr_checker
// Port-level checks for the motor speed ramp generator, bound to the top.
// ---------------------------------------------------------------------------
module msr_checker
  import msr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in flight");

  // direction pins are complementary and follow the sign
  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.pin_one != out_word.pin_two) &&
                  (out_word.pin_one == out_word.velocity[7]))
    else $error("bridge pins disagree with velocity sign");

  // duty is the magnitude of the velocity
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.velocity[7] ? (7'(-out_word.velocity) == out_word.duty)
                                        : (7'(out_word.velocity) == out_word.duty)))
    else $error("duty differs from velocity magnitude");

  // velocity stays within plus or minus 100
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.velocity <= VEL_MAX) && (out_word.velocity >= VEL_MIN))
    else $error("velocity out of range");

endmodule

bind motor_speed_ramp_hbridge msr_checker u_msr_checker (.*);

[tb/motor_speed_ramp_hbridge_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_speed_ramp_hbridge_test
// Self-checking bench for the H-bridge speed ramp generator. A short table of
// directed words covers reset drive, clamping, instant changes, ramp end,
// restart mid-ramp, abort and the spare kind. Random ramp sequences with
// noise follow. Every result word is compared against the table's drive or a
// local predictor, over four phases: no idling, input gaps, output stalls, both.
// ---------------------------------------------------------------------------
module motor_speed_ramp_hbridge_test;
  import msr_pkg::*;

  localparam int TICK_BITS    = 24;
  localparam int RANDOM_WORDS = 1230;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 40;

  // Spare kind, not decoded by the block
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Drives that can be read straight off the spec
  localparam out_word_t DRIVE_STOPPED = '{motor_out: 1'b0, velocity: 8'sd0, duty: 7'd0,
                                         pin_one: 1'b0, pin_two: 1'b1, ramp_active: 1'b0};
  localparam out_word_t DRIVE_A_REV   = '{motor_out: 1'b0, velocity: -8'sd100, duty: 7'd100,
                                         pin_one: 1'b1, pin_two: 1'b0, ramp_active: 1'b0};
  localparam out_word_t DRIVE_B_REV   = '{motor_out: 1'b1, velocity: -8'sd100, duty: 7'd100,
                                         pin_one: 1'b1, pin_two: 1'b0, ramp_active: 1'b0};
  localparam out_word_t DRIVE_B_RAMP  = '{motor_out: 1'b1, velocity: -8'sd100, duty: 7'd100,
                                         pin_one: 1'b1, pin_two: 1'b0, ramp_active: 1'b1};

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } vector_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  vector_t   plan[$];
  out_word_t drive_due[$];
  int        phase = 0;

  // Predictor state
  logic      ramp_on = 1'b0;
  logic      motor_q = 1'b0;
  int        from_v = 0;
  int        to_v = 0;
  int        now_v = 0;
  longint    span_q = 0;
  longint    elapsed_q = 0;

  // Run statistics
  int        n_planned = 0;
  int        n_start = 0;
  int        n_tick = 0;
  int        n_abort = 0;
  int        n_spare = 0;
  int        n_ramp_end = 0;
  int        n_checked = 0;
  int        n_fault = 0;
  int        quiet_cycles = 0;

  always #2 clk = ~clk;

  motor_speed_ramp_hbridge #(.TICK_BITS(TICK_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int clamp_pct(input int v);
    if (v > int'(VEL_MAX)) return int'(VEL_MAX);
    if (v < int'(VEL_MIN)) return int'(VEL_MIN);
    return v;
  endfunction

  // Velocity code: mostly in range, the rest anywhere in the 8-bit space
  function automatic logic [7:0] rand_pct();
    int v;
    if (chance(60)) v = int'($urandom_range(0, 200)) - 100;
    else v = int'($urandom_range(0, 255)) - 128;
    return v[7:0];
  endfunction

  // Word of the given kind with every other field random
  function automatic in_word_t raw_word(input logic [1:0] k);
    logic [63:0] raw;
    in_word_t    w;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.kind = k;
    return w;
  endfunction

  // Drive after one accepted word; updates the predicted ramp state
  function automatic out_word_t advance_ramp(input in_word_t w);
    out_word_t r;
    int        s;
    int        e;
    int        mag;
    longint    num;
    s = clamp_pct(int'(w.start_velocity));
    e = clamp_pct(int'(w.end_velocity));
    case (w.kind)
      KIND_START: begin
        motor_q   = w.motor_sel;
        from_v    = s;
        to_v      = e;
        span_q    = longint'(w.ramp_ticks) & ((longint'(1) << TICK_BITS) - 1);
        elapsed_q = 0;
        if (s == e || span_q == 0) begin
          ramp_on = 1'b0;
          now_v   = e;
        end else begin
          ramp_on = 1'b1;
          now_v   = s;
        end
      end
      KIND_TICK: begin
        if (ramp_on) begin
          elapsed_q = elapsed_q + 1;
          if (elapsed_q > span_q) begin
            ramp_on = 1'b0;
            n_ramp_end++;
          end else begin
            // exact interpolation, truncated toward zero
            num   = longint'(from_v) * span_q + elapsed_q * longint'(to_v - from_v);
            now_v = clamp_pct(int'(num / span_q));
          end
        end
      end
      KIND_ABORT: ramp_on = 1'b0;
      default: ;
    endcase
    mag = (now_v < 0) ? -now_v : now_v;
    if (mag > 100) mag = 100;
    r.motor_out   = motor_q;
    r.velocity    = now_v[7:0];
    r.duty        = mag[6:0];
    r.pin_one     = (now_v < 0);
    r.pin_two     = (now_v >= 0);
    r.ramp_active = ramp_on;
    return r;
  endfunction

  task automatic queue_word(input in_word_t w, input logic typed, input out_word_t want);
    plan.push_back('{word: w, typed: typed, want: want});
    if (w.kind != KIND_SPARE) n_planned++;
  endtask

  task automatic row(input logic [1:0] k, input logic sel, input int sv, input int ev,
                     input int unsigned tk, input logic typed, input out_word_t want);
    in_word_t w;
    w.kind           = k;
    w.motor_sel      = sel;
    w.start_velocity = sv[7:0];
    w.end_velocity   = ev[7:0];
    w.ramp_ticks     = tk[23:0];
    queue_word(w, typed, want);
  endtask

  // Stimulus: directed table, random sequences, then drain
  initial begin : stimulus
    in_word_t    w;
    out_word_t   drive;
    int          pick;
    int          n_ticks;
    int unsigned u;

    // after reset, spare kind and clamping
    row(KIND_TICK,  1'b0,    0,    0, 0,         1'b1, DRIVE_STOPPED);
    row(KIND_ABORT, 1'b1,   12,  -12, 9,         1'b1, DRIVE_STOPPED);
    row(KIND_SPARE, 1'b1, -128,  127, 24'hFFFFFF, 1'b1, DRIVE_STOPPED);
    row(KIND_START, 1'b1,  127, -128, 0,         1'b1, DRIVE_B_REV);
    row(KIND_START, 1'b0, -128, -100, 5,         1'b1, DRIVE_A_REV);
    // longest span, then tick, abort, and tick with nothing running
    row(KIND_START, 1'b1, -100,  100, 24'hFFFFFF, 1'b1, DRIVE_B_RAMP);
    row(KIND_TICK,  1'b0,   77,  -77, 24'hABCDEF, 1'b0, DRIVE_STOPPED);
    row(KIND_ABORT, 1'b0,    0,    0, 0,         1'b0, DRIVE_STOPPED);
    row(KIND_TICK,  1'b1,    0,    0, 0,         1'b0, DRIVE_STOPPED);
    // short ramp through zero, run past its end
    row(KIND_START, 1'b0,   -5,    5, 3,         1'b0, DRIVE_STOPPED);
    repeat (5) row(KIND_TICK, 1'b0, 0, 0, 0,    1'b0, DRIVE_STOPPED);
    // restart mid-ramp, spare kind while ramping
    row(KIND_START, 1'b0,    0,  127, 2,         1'b0, DRIVE_STOPPED);
    row(KIND_TICK,  1'b0,    0,    0, 0,         1'b0, DRIVE_STOPPED);
    row(KIND_START, 1'b1,   50,  -50, 1,         1'b0, DRIVE_STOPPED);
    row(KIND_SPARE, 1'b0,  -90,   90, 4,         1'b0, DRIVE_STOPPED);
    row(KIND_TICK,  1'b0,    0,    0, 0,         1'b0, DRIVE_STOPPED);
    row(KIND_TICK,  1'b0,    0,    0, 0,         1'b0, DRIVE_STOPPED);
    // equal ends: instant stop on motor A
    row(KIND_START, 1'b0,    0,    0, 7,         1'b1, DRIVE_STOPPED);
    row(KIND_ABORT, 1'b0,    0,    0, 0,         1'b0, DRIVE_STOPPED);

    // random part: mostly whole ramps, some noise and broken sequences
    while (n_planned < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        w = raw_word(KIND_START);
        w.start_velocity = rand_pct();
        w.end_velocity   = rand_pct();
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          u = $urandom_range(1, 24);
          w.ramp_ticks = u[23:0];
        end else if (pick < 90) begin
          w.ramp_ticks = '0;
        end
        queue_word(w, 1'b0, DRIVE_STOPPED);
        if (pick < 80) begin
          if (chance(25)) n_ticks = $urandom_range(0, int'(w.ramp_ticks));
          else n_ticks = int'(w.ramp_ticks) + int'($urandom_range(1, 2));
        end else begin
          n_ticks = $urandom_range(0, 6);
        end
        repeat (n_ticks) begin
          if (chance(4)) queue_word(raw_word(KIND_SPARE), 1'b0, DRIVE_STOPPED);
          queue_word(raw_word(KIND_TICK), 1'b0, DRIVE_STOPPED);
        end
        if (chance(20)) queue_word(raw_word(KIND_ABORT), 1'b0, DRIVE_STOPPED);
      end else if (pick < 85) begin
        u = $urandom_range(0, 3);
        queue_word(raw_word(u[1:0]), 1'b0, DRIVE_STOPPED);
      end else begin
        // broken: start cut short by abort or another start
        queue_word(raw_word(KIND_START), 1'b0, DRIVE_STOPPED);
        if (chance(50)) queue_word(raw_word(KIND_TICK), 1'b0, DRIVE_STOPPED);
        queue_word(raw_word(chance(50) ? KIND_ABORT : KIND_START), 1'b0, DRIVE_STOPPED);
        queue_word(raw_word(KIND_TICK), 1'b0, DRIVE_STOPPED);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      phase = i * 4 / plan.size();
      while (chance((phase == 1) ? 72 : (phase == 3) ? 9 : 0)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_word  <= plan[i].word;
      do @(posedge clk); while (in_stall);
      drive = advance_ramp(plan[i].word);
      drive_due.push_back(plan[i].typed ? plan[i].want : drive);
      case (plan[i].word.kind)
        KIND_START: n_start++;
        KIND_TICK:  n_tick++;
        KIND_ABORT: n_abort++;
        default:    n_spare++;
      endcase
    end
    in_valid <= 1'b0;

    while (drive_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d words (%0d starts, %0d ticks, %0d aborts, %0d spare kind)",
             plan.size(), n_start, n_tick, n_abort, n_spare);
    $display("run: %0d drives checked, %0d ramps ran out, %0d faults",
             n_checked, n_ramp_end, n_fault);
    if (n_fault == 0 && drive_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stall, compare with the oldest pending drive
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (drive_due.size() == 0) begin
        n_fault++;
        if (n_fault <= 10)
          $display("fault: result word with none pending, got %h", out_word);
      end else begin
        want = drive_due.pop_front();
        if (out_word.motor_out !== want.motor_out || out_word.velocity !== want.velocity ||
            out_word.duty !== want.duty || out_word.pin_one !== want.pin_one ||
            out_word.pin_two !== want.pin_two ||
            out_word.ramp_active !== want.ramp_active) begin
          n_fault++;
          if (n_fault <= 10)
            $display("fault at drive %0d: expected m%0d v%0d d%0d pins %b%b act %b,",
                     n_checked, want.motor_out, want.velocity, want.duty, want.pin_one,
                     want.pin_two, want.ramp_active,
                     " got m%0d v%0d d%0d pins %b%b act %b", out_word.motor_out,
                     out_word.velocity, out_word.duty, out_word.pin_one, out_word.pin_two,
                     out_word.ramp_active);
        end
      end
    end
    out_stall <= chance((phase == 2) ? 72 : (phase == 3) ? 9 : 0);
  end

  // Watchdog: cycles since the last word moved on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d drives pending",
                 quiet_cycles, drive_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

[sim.f]
src/msr_pkg.sv
src/msr_divider.sv
src/motor_speed_ramp_hbridge.sv
src/msr_checker.sv
tb/motor_speed_ramp_hbridge_test.sv
